/* hw/rtl/sha_pkg.sv */
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the sequencer enums, the control structs between the blocks and the round constants.
// No dependencies.
`default_nettype none

package sha_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_DATA_END,
    BLK_EXTRA,
    BLK_LAST
  } blk_kind_t;

  typedef struct packed {
    logic        wr_byte;
    logic        pad;
    logic        len_only;
    logic        shift;
    logic [5:0]  fill;
    logic [7:0]  data;
    logic [63:0] length;
  } sched_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic add;
    logic init;
  } round_ctrl_t;

  localparam logic [5:0] LastByte = 6'd63;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [63:0] BitsPerByte = 64'd8;

  localparam word_t INIT_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

/* hw/rtl/sha_sched.sv */
// Block buffer and message schedule window for the SHA-256 hasher.
// Gathers bytes, applies padding and shifts out one schedule word per round.
// Depends on sha_pkg.
`default_nettype none

module sha_sched (
  input  wire logic                 clk,
  input  wire sha_pkg::sched_ctrl_t ctrl,
  output sha_pkg::word_t            w_t
);

  sha_pkg::word_t [15:0] w;
  sha_pkg::word_t [15:0] w_next;
  sha_pkg::word_t        s0;
  sha_pkg::word_t        s1;

  assign s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
  assign w_t = w[0];

  always_comb begin
    logic [5:0] j;
    w_next = w;
    j = '0;
    if (ctrl.wr_byte) begin
      for (int i = 0; i < 16; i++) begin
        for (int b = 0; b < 4; b++) begin
          j = 6'(i * 4 + b);
          if (j == ctrl.fill) begin
            w_next[i][31 - 8 * b -: 8] = ctrl.data;
          end
        end
      end
    end else if (ctrl.pad) begin
      for (int i = 0; i < 16; i++) begin
        for (int b = 0; b < 4; b++) begin
          j = 6'(i * 4 + b);
          if (j == ctrl.fill) begin
            w_next[i][31 - 8 * b -: 8] = sha_pkg::PadByte;
          end else if (j > ctrl.fill) begin
            w_next[i][31 - 8 * b -: 8] = '0;
          end
        end
      end
      if (ctrl.fill < sha_pkg::LenStart) begin
        w_next[14] = ctrl.length[63:32];
        w_next[15] = ctrl.length[31:0];
      end
    end else if (ctrl.len_only) begin
      w_next = '0;
      w_next[14] = ctrl.length[63:32];
      w_next[15] = ctrl.length[31:0];
    end else if (ctrl.shift) begin
      for (int i = 0; i < 15; i++) begin
        w_next[i] = w[i + 1];
      end
      w_next[15] = s1 + w[9] + s0 + w[0];
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/sha_round.sv */
// Shared SHA-256 round unit with the working variables and the chaining words.
// One round per cycle under the sequencer, then a feed-forward add into the chain.
// Depends on sha_pkg.
`default_nettype none

module sha_round (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sha_pkg::round_ctrl_t         ctrl,
  input  wire sha_pkg::word_t               k,
  input  wire sha_pkg::word_t               w,
  output sha_pkg::word_t [7:0]              chain
);

  sha_pkg::word_t [7:0] v;
  sha_pkg::word_t       t1;
  sha_pkg::word_t       t2;
  sha_pkg::word_t       bs0;
  sha_pkg::word_t       bs1;
  sha_pkg::word_t       ch;
  sha_pkg::word_t       maj;

  assign bs0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^
               {v[0][21:0], v[0][31:22]};
  assign bs1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^
               {v[4][24:0], v[4][31:25]};
  assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1  = v[7] + bs1 + ch + k + w;
  assign t2  = bs0 + maj;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      v <= chain;
    end else if (ctrl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= sha_pkg::INIT_WORDS[i];
      end
    end else if (ctrl.add) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sha256_byte_stream_hasher_core.sv */
// Top level of the SHA-256 byte stream hasher: sequencer, byte count, length and digest register.
// Instantiates sha_sched and sha_round; depends on sha_pkg.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   data_byte, byte_valid, msg_end
//   out      output     out_valid/out_stall digest_part0..digest_part3
//
// A byte that does not complete a block and does not end the message leaves the input open.
// A full block is compressed in steps: load, 64 rounds of the shared round unit, chain add.
// A message end adds a padding step, a compression per padding block and a done step; a second
// padding block first sets up its length words in a step of its own.
// in_stall is high while a block compresses and until the digest is loaded; the digest register
// lets bytes of the next message in while a digest waits. Synchronous reset, no clearing pass.
`default_nettype none

module sha256_byte_stream_hasher_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        msg_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      digest_part0,
  output logic [63:0]      digest_part1,
  output logic [63:0]      digest_part2,
  output logic [63:0]      digest_part3
);

  sha_pkg::state_t      state;
  sha_pkg::state_t      state_next;
  sha_pkg::blk_kind_t   kind;
  sha_pkg::blk_kind_t   kind_next;
  logic [5:0]           fill;
  logic [5:0]           fill_next;
  logic [63:0]          total_bits;
  logic [63:0]          total_bits_next;
  logic [5:0]           rnd;
  logic [5:0]           rnd_next;
  logic                 out_valid_next;
  logic                 accept;
  logic                 out_load;
  sha_pkg::sched_ctrl_t sched_ctrl;
  sha_pkg::round_ctrl_t round_ctrl;
  sha_pkg::word_t       w_t;
  sha_pkg::word_t [7:0] chain;

  assign in_stall = (state != sha_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;

  sha_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w_t  (w_t)
  );

  sha_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (round_ctrl),
    .k     (sha_pkg::ROUND_K[rnd]),
    .w     (w_t),
    .chain (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha_pkg::ST_IDLE;
      kind <= sha_pkg::BLK_DATA;
      fill <= '0;
      total_bits <= '0;
      rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind <= kind_next;
      fill <= fill_next;
      total_bits <= total_bits_next;
      rnd <= rnd_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    kind_next = kind;
    fill_next = fill;
    total_bits_next = total_bits;
    rnd_next = rnd;
    out_load = 1'b0;
    sched_ctrl = '0;
    sched_ctrl.fill = fill;
    sched_ctrl.data = data_byte;
    sched_ctrl.length = total_bits;
    round_ctrl = '0;
    case (state)
      sha_pkg::ST_IDLE: begin
        if (accept) begin
          if (byte_valid) begin
            sched_ctrl.wr_byte = 1'b1;
            fill_next = fill + 6'd1;
            total_bits_next = total_bits + sha_pkg::BitsPerByte;
            if (fill == sha_pkg::LastByte) begin
              kind_next = msg_end ? sha_pkg::BLK_DATA_END : sha_pkg::BLK_DATA;
              state_next = sha_pkg::ST_LOAD;
            end else if (msg_end) begin
              state_next = sha_pkg::ST_PAD;
            end
          end else if (msg_end) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        sched_ctrl.pad = 1'b1;
        kind_next = (fill >= sha_pkg::LenStart) ? sha_pkg::BLK_EXTRA : sha_pkg::BLK_LAST;
        state_next = sha_pkg::ST_LOAD;
      end
      sha_pkg::ST_LEN: begin
        sched_ctrl.len_only = 1'b1;
        kind_next = sha_pkg::BLK_LAST;
        state_next = sha_pkg::ST_LOAD;
      end
      sha_pkg::ST_LOAD: begin
        round_ctrl.load = 1'b1;
        rnd_next = '0;
        state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        round_ctrl.step = 1'b1;
        sched_ctrl.shift = 1'b1;
        rnd_next = rnd + 6'd1;
        if (rnd == sha_pkg::LastByte) begin
          state_next = sha_pkg::ST_ADD;
        end
      end
      sha_pkg::ST_ADD: begin
        round_ctrl.add = 1'b1;
        case (kind)
          sha_pkg::BLK_DATA:     state_next = sha_pkg::ST_IDLE;
          sha_pkg::BLK_DATA_END: state_next = sha_pkg::ST_PAD;
          sha_pkg::BLK_EXTRA:    state_next = sha_pkg::ST_LEN;
          sha_pkg::BLK_LAST:     state_next = sha_pkg::ST_DONE;
          default:               state_next = sha_pkg::ST_IDLE;
        endcase
      end
      sha_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          round_ctrl.init = 1'b1;
          fill_next = '0;
          total_bits_next = '0;
          state_next = sha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sha_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_part0 <= {chain[0], chain[1]};
      digest_part1 <= {chain[2], chain[3]};
      digest_part2 <= {chain[4], chain[5]};
      digest_part3 <= {chain[6], chain[7]};
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == sha_pkg::ST_DONE))
    else $error("Digest transfer raised outside the done step.");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == sha_pkg::ST_ROUND && rnd == sha_pkg::LastByte) |=> state == sha_pkg::ST_ADD)
    else $error("Compression did not end after the last round.");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_valid && fill == sha_pkg::LastByte) |=>
      (state == sha_pkg::ST_LOAD && fill == '0))
    else $error("A full block did not start compression.");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (state == sha_pkg::ST_DONE && !out_valid) |=>
      (out_valid && fill == '0 && total_bits == '0 && state == sha_pkg::ST_IDLE))
    else $error("Message state was not restarted with the digest.");

endmodule

`default_nettype wire

/* tb/sha256_byte_stream_hasher_core_checker.sv */
`timescale 1ns / 100ps
// Checker for the SHA-256 byte stream hasher: watches both channels, predicts each digest
// from the accepted input transfers and compares it with the digest the block returns.
// Depends on sha_pkg for the word type, the initial hash values and the round constants.

module sha256_byte_stream_hasher_core_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        msg_end,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [63:0] digest_part0,
  input  wire logic [63:0] digest_part1,
  input  wire logic [63:0] digest_part2,
  input  wire logic [63:0] digest_part3,
  output int               digests_waiting,
  output int               fail_count
);

  typedef logic [3:0][63:0] digest_t;

  sha_pkg::word_t hash_chain [8];
  logic [7:0]     msg_block [64];
  int             block_fill;
  logic [63:0]    msg_bits;
  digest_t        expected_digests [$];
  digest_t        seen;
  digest_t        want;
  int             errors = 0;

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    sha_pkg::word_t w [64];
    sha_pkg::word_t v [8];
    sha_pkg::word_t s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {msg_block[4 * i], msg_block[4 * i + 1], msg_block[4 * i + 2], msg_block[4 * i + 3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3);
      s1 = rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10);
      w[i] = s1 + w[i - 7] + s0 + w[i - 16];
    end
    for (i = 0; i < 8; i++) v[i] = hash_chain[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) hash_chain[i] = hash_chain[i] + v[i];
  endfunction

  function automatic void restart_message();
    int i;
    for (i = 0; i < 8; i++) hash_chain[i] = sha_pkg::INIT_WORDS[i];
    block_fill = 0;
    msg_bits = '0;
  endfunction

  function automatic void absorb_transfer(logic [7:0] b, logic bv, logic e);
    digest_t d;
    int i;
    if (bv) begin
      msg_block[block_fill] = b;
      block_fill++;
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (e) begin
      msg_block[block_fill] = sha_pkg::PadByte;
      for (i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (block_fill >= 56) begin
        compress_block();
        for (i = 0; i < 56; i++) msg_block[i] = 8'h00;
      end
      for (i = 0; i < 8; i++) msg_block[56 + i] = msg_bits[63 - 8 * i -: 8];
      compress_block();
      for (i = 0; i < 4; i++) d[i] = {hash_chain[2 * i], hash_chain[2 * i + 1]};
      expected_digests.push_back(d);
      restart_message();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restart_message();
      expected_digests.delete();
    end else begin
      if (in_valid && !in_stall) absorb_transfer(data_byte, byte_valid, msg_end);
      if (out_valid && !out_stall) begin
        seen = {digest_part3, digest_part2, digest_part1, digest_part0};
        if (expected_digests.size() == 0) begin
          $display("%0t: digest transfer with none expected: expected none, actual %h",
                   $time, seen);
          errors++;
        end else begin
          want = expected_digests.pop_front();
          for (int p = 0; p < 4; p++) begin
            if (seen[p] !== want[p]) begin
              $display("%0t: digest_part%0d mismatch: expected %h, actual %h",
                       $time, p, want[p], seen[p]);
              errors++;
            end
          end
        end
      end
    end
    digests_waiting <= expected_digests.size();
    fail_count <= errors;
  end

endmodule

/* tb/sha256_byte_stream_hasher_core_test.sv */
`timescale 1ns / 100ps
// Top of the SHA-256 byte stream hasher testbench: clock, reset, byte stream stimulus with
// random gaps and digest stalls, and the verdict. Depends on the core and on the checker.

module sha256_byte_stream_hasher_core_test;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_valid = 1'b0;
  logic        msg_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] digest_part0;
  logic [63:0] digest_part1;
  logic [63:0] digest_part2;
  logic [63:0] digest_part3;
  int          digests_waiting;
  int          fail_count;
  bit          calm = 1'b0;

  sha256_byte_stream_hasher_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .msg_end      (msg_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_part0 (digest_part0),
    .digest_part1 (digest_part1),
    .digest_part2 (digest_part2),
    .digest_part3 (digest_part3)
  );

  sha256_byte_stream_hasher_core_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .byte_valid      (byte_valid),
    .msg_end         (msg_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .digest_part0    (digest_part0),
    .digest_part1    (digest_part1),
    .digest_part2    (digest_part2),
    .digest_part3    (digest_part3),
    .digests_waiting (digests_waiting),
    .fail_count      (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic bv, input logic e);
    while (!calm && ($urandom_range(0, 99) < 20)) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      byte_valid <= 1'($urandom);
      msg_end <= 1'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    byte_valid <= bv;
    msg_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int sent;
    int msg_len;
    bit bare_end;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    sent = 0;
    while (sent < 1650) begin
      calm = (sent >= 700) && (sent < 1000);
      case ($urandom_range(0, 19)) inside
        [0:10]: msg_len = $urandom_range(0, 20);
        [11:15]: begin
          case ($urandom_range(0, 10))
            0: msg_len = 55;
            1: msg_len = 56;
            2: msg_len = 57;
            3: msg_len = 62;
            4: msg_len = 63;
            5: msg_len = 64;
            6: msg_len = 65;
            7: msg_len = 119;
            8: msg_len = 120;
            9: msg_len = 127;
            default: msg_len = 128;
          endcase
        end
        [16:18]: msg_len = $urandom_range(21, 70);
        default: msg_len = $urandom_range(71, 200);
      endcase
      bare_end = (msg_len == 0) || ($urandom_range(0, 99) < 30);
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 99) < 4) begin
          send_item(8'($urandom), 1'b0, 1'b0);
          sent++;
        end
        send_item(8'($urandom), 1'b1, !bare_end && (k == msg_len - 1));
        sent++;
      end
      if (bare_end) begin
        send_item(8'($urandom), 1'b0, 1'b1);
        sent++;
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (digests_waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
